[hw/rtl/target_change_limiter_top_assert.svh]
// ----------------------------------------------------------------------------
// Target change limiter assertion macros
// Concurrent property wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TARGET_CHANGE_LIMITER_TOP_ASSERT_SVH
`define TARGET_CHANGE_LIMITER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define TCL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TCL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TCL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define TCL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[hw/rtl/tcl_pkg.sv]
// ----------------------------------------------------------------------------
// Target change limiter package
// Shared constants, field layout and controller command type.
// ----------------------------------------------------------------------------
package tcl_pkg;

  localparam int MAIN_SLOTS_DEF  = 10;
  localparam int REPLY_SLOTS_DEF = 5;

  localparam int HASH_W     = 32;
  localparam int TIME_W     = 32;
  localparam int CRED_W     = 4;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;

  localparam int REFILL_PERIOD = 60;
  // floor(x / 60) == (x * 2185) >> 17 for every x below 1920 (60 * 32)
  localparam int RECIP_MUL   = 2185;
  localparam int RECIP_SHIFT = 17;

  localparam logic FUNC_SEND  = 1'b0;
  localparam logic FUNC_REPLY = 1'b1;

  typedef struct packed {
    logic capture;
    logic commit;
  } tcl_cmd_t;

endpackage

[hw/rtl/target_change_limiter_top.sv]
// ----------------------------------------------------------------------------
// Target change limiter top level
// Recent-target list with credit limiting of sends to new targets.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tuser is the operation (send or
//   reply), s_tdata carries the target hash, the time in seconds and the
//   exempt and operator flags. Each request yields exactly one result on the
//   m_ channel: allowed flag and the free credit count after the request.
//   The result is registered in the output register when the request
//   commits, which waits until that register is free. Each request has
//   a capture step in the controller (list compare, elapsed time) and a
//   commit step (refill multiply, list shift, credit update); the next
//   request cannot be taken before the previous one has committed.
//   One request is in flight at a time; the next request is taken as soon
//   as the previous one has committed, even while its result still waits.
//   If the receiver stalls, a committed result holds in the output register
//   and the following request waits in its commit cycle until it drains.
//   Reset clears the list to zero, fills the credits, zeroes the refill time
//   and takes effect on the next cycle with no clearing pass.
// ----------------------------------------------------------------------------
`include "target_change_limiter_top_assert.svh"

module target_change_limiter_top import tcl_pkg::*; #(
  parameter int MAIN_SLOTS  = MAIN_SLOTS_DEF,
  parameter int REPLY_SLOTS = REPLY_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [31:0] target_hash, [63:32] now_seconds, [64] target_exempt,
  // [65] target_is_oper, [71:66] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] func
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] allowed, [4:1] credits_left, [7:5] zero
  output logic [OUT_DATA_W-1:0] m_tdata
);

  tcl_cmd_t cmd;

  tcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  tcl_dp #(
    .MAIN_SLOTS  (MAIN_SLOTS),
    .REPLY_SLOTS (REPLY_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_tdata),
    .in_func  (s_tuser),
    .out_data (m_tdata)
  );

  `TCL_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready, "second request taken before commit")
  `TCL_ASSERT_NEXT(a_commit_shows, clk, rst, cmd.commit, m_tvalid, "committed result not presented")
  `TCL_ASSERT_IMPL(a_no_overwrite, clk, rst, m_tvalid && !m_tready, !cmd.commit, "commit over a stalled result")

endmodule

[hw/rtl/tcl_ctrl.sv]
// ----------------------------------------------------------------------------
// Target change limiter controller
// Sequences capture and commit of one request and owns the result valid.
// ----------------------------------------------------------------------------
module tcl_ctrl import tcl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output tcl_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_t;

  state_t state;

  always_comb begin
    s_tready    = (state == ST_IDLE);
    cmd.capture = (state == ST_IDLE) && s_tvalid;
    cmd.commit  = (state == ST_UPD) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.capture) state <= ST_UPD;
        end
        ST_UPD: begin
          if (cmd.commit) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/tcl_dp.sv]
// ----------------------------------------------------------------------------
// Target change limiter datapath
// Recent-target shift list, credit counter with timed refill, result register.
// ----------------------------------------------------------------------------
module tcl_dp import tcl_pkg::*; #(
  parameter int MAIN_SLOTS  = MAIN_SLOTS_DEF,
  parameter int REPLY_SLOTS = REPLY_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tcl_cmd_t              cmd,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  in_func,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int DEPTH = MAIN_SLOTS + REPLY_SLOTS;
  localparam int CW    = $clog2(MAIN_SLOTS + 1);
  localparam int CLAMP = REFILL_PERIOD * MAIN_SLOTS;
  localparam int EW    = $clog2(CLAMP + 1);
  localparam int PW    = EW + 12;
  localparam int KW    = PW - RECIP_SHIFT;

  logic [HASH_W-1:0] list [DEPTH];
  logic [CW-1:0]     free_cred;
  logic [TIME_W-1:0] last_refill;
  logic              started;

  logic [HASH_W-1:0] hash_q;
  logic [TIME_W-1:0] now_q;
  logic              func_q;
  logic              bypass_q;
  logic [DEPTH:0]    seen_q;
  logic [EW-1:0]     ecl_q;

  // capture side
  logic [HASH_W-1:0] h_in;
  logic [TIME_W-1:0] now_in;
  logic              exempt_in;
  logic              oper_in;
  logic [DEPTH:0]    match;
  logic [DEPTH:0]    seen;
  logic [TIME_W-1:0] elapsed;
  logic [EW-1:0]     ecl;

  // commit side
  logic [PW-1:0]       prod;
  logic [KW-1:0]       kval;
  logic [PW-1:0]       sum;
  logic [CW-1:0]       refilled;
  logic                found;
  logic                allowed;
  logic                send_upd;
  logic                reply_upd;
  logic [CW-1:0]       free_mid;
  logic [CW-1:0]       free_next;
  logic [TIME_W-1:0]   last_next;
  logic                started_next;
  logic [HASH_W-1:0]   list_next [DEPTH];
  logic [CW+CRED_W-1:0] cred_ext;

  assign h_in      = in_data[HASH_W-1:0];
  assign now_in    = in_data[HASH_W+TIME_W-1:HASH_W];
  assign exempt_in = in_data[HASH_W+TIME_W];
  assign oper_in   = in_data[HASH_W+TIME_W+1];

  always_comb begin
    match = '0;
    for (int j = 0; j < DEPTH; j++) begin
      match[j] = (list[j] == h_in);
    end
    // seen[j]: some entry below j already holds the hash
    for (int j = 0; j <= DEPTH; j++) begin
      seen[j] = |(match & (((DEPTH+1)'(1) << j) - (DEPTH+1)'(1)));
    end
    elapsed = (now_in > last_refill) ? (now_in - last_refill) : '0;
    // past the clamp the refill saturates anyway
    ecl = (elapsed >= TIME_W'(CLAMP)) ? EW'(CLAMP) : elapsed[EW-1:0];
  end

  always_comb begin
    prod     = PW'(ecl_q) * PW'(RECIP_MUL);
    kval     = prod[PW-1:RECIP_SHIFT];
    sum      = PW'(free_cred) + PW'(kval);
    refilled = (sum > PW'(MAIN_SLOTS)) ? CW'(MAIN_SLOTS) : sum[CW-1:0];
    found    = seen_q[DEPTH];

    allowed      = 1'b1;
    send_upd     = 1'b0;
    reply_upd    = 1'b0;
    free_mid     = free_cred;
    free_next    = free_cred;
    last_next    = last_refill;
    started_next = started;

    if (func_q == FUNC_SEND) begin
      if (bypass_q) begin
        allowed = 1'b1;
      end else if (found) begin
        send_upd = 1'b1;
      end else begin
        if (free_cred < CW'(MAIN_SLOTS)) begin
          if (!started) begin
            started_next = 1'b1;
            last_next    = now_q;
          end else if (kval != '0) begin
            free_mid  = refilled;
            last_next = now_q;
          end else if (free_cred == '0) begin
            allowed = 1'b0;
          end
        end else begin
          last_next    = now_q;
          started_next = 1'b1;
        end
        if (allowed) begin
          send_upd  = 1'b1;
          free_next = (free_mid == '0) ? '0 : free_mid - CW'(1);
        end
      end
    end else begin
      reply_upd = !bypass_q;
    end

    for (int j = 0; j < DEPTH; j++) begin
      list_next[j] = list[j];
    end
    if (send_upd) begin
      list_next[0] = hash_q;
      for (int j = 1; j < DEPTH; j++) begin
        if (!seen_q[j]) list_next[j] = list[j-1];
      end
    end
    if (reply_upd) begin
      if (!seen_q[MAIN_SLOTS+1]) list_next[MAIN_SLOTS] = hash_q;
      for (int j = MAIN_SLOTS + 1; j < DEPTH; j++) begin
        if (!seen_q[j]) list_next[j] = list[j-1];
      end
    end

    cred_ext = (CW+CRED_W)'(free_next);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hash_q   <= h_in;
      now_q    <= now_in;
      func_q   <= in_func;
      // exempt skips everything; an operator skips sends while the clock is behind
      bypass_q <= exempt_in || (in_func == FUNC_SEND && oper_in && last_refill > now_in);
      seen_q   <= seen;
      ecl_q    <= ecl;
    end
    if (cmd.commit) begin
      out_data <= {(OUT_DATA_W-CRED_W-1)'(0), cred_ext[CRED_W-1:0], allowed};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DEPTH; j++) begin
        list[j] <= '0;
      end
      free_cred   <= CW'(MAIN_SLOTS);
      last_refill <= '0;
      started     <= 1'b0;
    end else if (cmd.commit) begin
      for (int j = 0; j < DEPTH; j++) begin
        list[j] <= list_next[j];
      end
      free_cred   <= free_next;
      last_refill <= last_next;
      started     <= started_next;
    end
  end

endmodule
